>>> sv/smpq_pkg.sv
// Shared types and codes for the sorted max-priority queue.
`default_nettype none

package smpq_pkg;

    localparam int unsigned DEF_CAPACITY = 16;
    localparam int unsigned VALUE_W      = 32;
    localparam int unsigned COUNT_OUT_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL_REJ   = 2'd1,
        ST_EMPTY_REJ  = 2'd2
    } t_status;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                        ins;
        logic                        del;
        logic signed [VALUE_W-1:0]   value;
    } t_cmd;

endpackage

`default_nettype wire

>>> sv/smpq_cell.sv
// One slot of the descending row: hold, take the new value, or shift.
`default_nettype none

module smpq_cell (
    input  wire logic                                   i_clk,
    input  wire smpq_pkg::t_cmd                         i_cmd,
    input  wire logic                                   i_occ,
    input  wire logic                                   i_up_keep,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    i_up_value,
    input  wire logic signed [smpq_pkg::VALUE_W-1:0]    i_dn_value,
    output logic                                        o_keep,
    output logic signed [smpq_pkg::VALUE_W-1:0]         o_value,
    output logic signed [smpq_pkg::VALUE_W-1:0]         o_next
);

    logic signed [smpq_pkg::VALUE_W-1:0] r_value;
    logic signed [smpq_pkg::VALUE_W-1:0] n_value;

    // An occupied slot at or above the new value stays put on insert.
    assign o_keep = i_occ && !(i_cmd.value > r_value);

    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_value = r_value;
            end else if (i_up_keep) begin
                n_value = i_cmd.value;
            end else begin
                n_value = i_up_value;
            end
        end else if (i_cmd.del) begin
            n_value = i_dn_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_next  = n_value;

endmodule

`default_nettype wire

>>> sv/sorted_max_priority_queue.sv
// Bounded max-priority queue built from a row of shift-compare cells.
// Usage:
//   Slave channel: i_s_axis_tuser selects the request (0 insert, 1 delete
//   maximum), i_s_axis_tdata carries the signed value to insert.
//   Master channel: one result per request with the new maximum, empty and
//   full flags, entry count and status (0 ok, 1 insert rejected because
//   full, 2 delete rejected because empty; a rejected request changes
//   nothing).
//   Values sit in descending order, slot 0 holding the maximum. On insert
//   every cell compares the new value with its own and with its upper
//   neighbor's decision, then holds, takes the value or shifts down; on
//   delete every cell takes its lower neighbor's value.
//   The result is registered and is presented in the cycle after the request is taken.
//   Throughput: one request per cycle while the receiver is ready; the
//   cycle is set by one 32-bit compare in a cell plus its neighbor's select.
//   Reset empties the queue and drops any pending result.
//   When the receiver stalls, the result is held and a new request is
//   taken only in the cycle the held result leaves.
`default_nettype none

module sorted_max_priority_queue #(
    parameter int unsigned CAPACITY = smpq_pkg::DEF_CAPACITY
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  wire logic [31:0]    i_s_axis_tdata,   // [31:0] value
    input  wire logic [0:0]     i_s_axis_tuser,   // [0] action
    output logic                o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    // [31:0] top_value, [32] is_empty, [33] is_full, [38:34] entry_count,
    // [40:39] status, [47:41] zero
    output logic [47:0]         o_m_axis_tdata
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned VW = smpq_pkg::VALUE_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic signed [VW-1:0]   r_top;
    logic                   r_empty;
    logic                   r_full;
    logic [smpq_pkg::COUNT_OUT_W-1:0] r_cnt_out;
    smpq_pkg::t_status      r_status;
    smpq_pkg::t_status      n_status;

    logic                   accept;
    logic                   q_full;
    logic                   q_empty;
    smpq_pkg::t_cmd         cmd;

    logic                   keep   [CAPACITY];
    logic signed [VW-1:0]   value  [CAPACITY];
    logic signed [VW-1:0]   nxt    [CAPACITY];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign q_full  = (r_count == CW'(CAPACITY));
    assign q_empty = (r_count == '0);

    always_comb begin
        cmd.ins   = accept && (i_s_axis_tuser[0] == smpq_pkg::ACT_INSERT) && !q_full;
        cmd.del   = accept && (i_s_axis_tuser[0] == smpq_pkg::ACT_DELETE) && !q_empty;
        cmd.value = $signed(i_s_axis_tdata);
        n_status  = smpq_pkg::ST_OK;
        if (i_s_axis_tuser[0] == smpq_pkg::ACT_INSERT) begin
            if (q_full) n_status = smpq_pkg::ST_FULL_REJ;
        end else begin
            if (q_empty) n_status = smpq_pkg::ST_EMPTY_REJ;
        end
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                 up_keep;
        logic signed [VW-1:0] up_value;
        logic signed [VW-1:0] dn_value;

        if (i == 0) begin : g_first
            assign up_keep  = 1'b1;
            assign up_value = '0;
        end else begin : g_mid
            assign up_keep  = keep[i-1];
            assign up_value = value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign dn_value = '0;
        end else begin : g_inner
            assign dn_value = value[i+1];
        end

        smpq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_occ      (r_count > CW'(i)),
            .i_up_keep  (up_keep),
            .i_up_value (up_value),
            .i_dn_value (dn_value),
            .o_keep     (keep[i]),
            .o_value    (value[i]),
            .o_next     (nxt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result of the step; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top     <= (n_count == '0) ? '0 : nxt[0];
            r_empty   <= (n_count == '0);
            r_full    <= (n_count == CW'(CAPACITY));
            r_cnt_out <= smpq_pkg::COUNT_OUT_W'(n_count);
            r_status  <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_status, r_cnt_out, r_full, r_empty, r_top};

endmodule

`default_nettype wire

>>> sv/smpq_chk.sv
// Port-level checks for the sorted max-priority queue, bound to the top level.
`default_nettype none

module smpq_chk (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_axis_tvalid,
    input  wire logic           o_s_axis_tready,
    input  wire logic           o_m_axis_tvalid,
    input  wire logic           i_m_axis_tready,
    input  wire logic [47:0]    o_m_axis_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // An accepted request yields a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("no result after accepted request");

    // Empty queue reports zero count and zero top.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[32] |->
            o_m_axis_tdata[38:34] == 5'd0 && o_m_axis_tdata[31:0] == 32'd0
            && !o_m_axis_tdata[33])
        else $error("empty flag inconsistent");

    // Status is a known code and rejections match the flags.
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[40:39] == smpq_pkg::ST_OK
            || (o_m_axis_tdata[40:39] == smpq_pkg::ST_FULL_REJ && o_m_axis_tdata[33])
            || (o_m_axis_tdata[40:39] == smpq_pkg::ST_EMPTY_REJ && o_m_axis_tdata[32]))
        else $error("status inconsistent with flags");

endmodule

bind sorted_max_priority_queue smpq_chk u_smpq_chk (.*);

`default_nettype wire
